// ----- hdl/rac_pkg.sv -----
// Shared types and codes for the rational accumulator.
package rac_pkg;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_ADD  = 3'd1,
        OP_INC  = 3'd2,
        OP_DEC  = 3'd3,
        OP_CMP  = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_GCD_START,
        ST_GCD_DIV,
        ST_Q1_START,
        ST_Q1_DIV,
        ST_Q2_START,
        ST_Q2_DIV,
        ST_STORE,
        ST_OUT
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch the input transaction
        logic mul1;        // first product step
        logic mul2;        // second product step, builds n
        logic gcd_init;    // set up the Euclid pair
        logic gcd_step;    // replace (x, y) with (y, x rem y)
        logic div_num;     // start divide n / g
        logic div_den;     // start divide d / g
        logic div_start;   // launch the divider
        logic save_qn;     // save the numerator quotient
        logic store;       // write the reduced fraction
        logic store_err;   // keep state, flag error
        logic do_inc;      // increment path
        logic do_cmp;      // compare path
        logic do_none;     // no datapath action, asserted in ST_STORE
    } cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       y_zero;
        logic       g_zero;
        logic [2:0] op;
    } status_t;

endpackage

// ----- hdl/rac_divider.sv -----
// Restoring signed divider with truncating quotient and remainder, one bit a cycle.
module rac_divider #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 done,
    output logic [WORD_BITS-1:0] quot,
    output logic [WORD_BITS-1:0] rem
);

    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] q_reg, q_next;
    logic [WORD_BITS:0]   r_reg, r_next;
    logic [WORD_BITS-1:0] d_reg, d_next;
    logic                 qneg_reg, qneg_next;
    logic                 rneg_reg, rneg_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   shifted;

    // one shift-subtract step per cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg[WORD_BITS-1:0], q_reg[WORD_BITS-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
            d_next    = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
            r_next    = '0;
            qneg_next = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
            rneg_next = dividend[WORD_BITS-1];
            cnt_next  = CW'(WORD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_BITS])
            begin
                r_next = trial;
                q_next = {q_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[WORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done = done_reg;
    assign quot = qneg_reg ? (~q_reg + 1'b1) : q_reg;
    assign rem  = rneg_reg ? (~r_reg[WORD_BITS-1:0] + 1'b1) : r_reg[WORD_BITS-1:0];

endmodule

// ----- hdl/rac_datapath.sv -----
// Datapath: stored fraction, products, Euclid pair and shared divider.
module rac_datapath #(
    parameter int WORD_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rac_pkg::cmd_t    cmd,
    output rac_pkg::status_t status,
    input  logic [2:0]       op,
    input  logic signed [31:0] in_num,
    input  logic signed [31:0] in_den,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic             nonzero,
    output logic             equal,
    output logic             div_error
);

    logic [WORD_BITS-1:0] sn_reg, sd_reg;
    logic [WORD_BITS-1:0] an_reg, ad_reg;
    logic [WORD_BITS-1:0] n_reg, d_reg;
    logic [WORD_BITS-1:0] p_reg;
    logic [WORD_BITS-1:0] x_reg, y_reg;
    logic [WORD_BITS-1:0] qn_reg;
    logic [2:0]           op_reg;
    logic                 eq_reg, err_reg;
    logic [WORD_BITS-1:0] div_a, div_b, quot, rem;
    logic                 div_done;
    logic [WORD_BITS-1:0] in_num_w, in_den_w;

    // bring the 32-bit fields to the word width by sign extension
    assign in_num_w = WORD_BITS'({{WORD_BITS{in_num[31]}}, in_num});
    assign in_den_w = WORD_BITS'({{WORD_BITS{in_den[31]}}, in_den});

    // divider operands follow the phase
    always_comb
    begin
        if (cmd.div_num)
        begin
            div_a = n_reg;
            div_b = x_reg;
        end
        else if (cmd.div_den)
        begin
            div_a = d_reg;
            div_b = x_reg;
        end
        else
        begin
            div_a = x_reg;
            div_b = y_reg;
        end
    end

    rac_divider #(.WORD_BITS(WORD_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sn_reg <= '0;
            sd_reg <= WORD_BITS'(1);
        end
        else if (cmd.store)
        begin
            sn_reg <= qn_reg;
            sd_reg <= quot;
        end
        else if (cmd.do_inc)
        begin
            sn_reg <= sn_reg + sd_reg;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            err_reg <= 1'b0;
            if (op == rac_pkg::OP_DEC)
            begin
                an_reg <= '1;
                ad_reg <= WORD_BITS'(1);
            end
            else
            begin
                an_reg <= in_num_w;
                ad_reg <= in_den_w;
            end
            // load reduces the input itself
            n_reg <= in_num_w;
            d_reg <= in_den_w;
            eq_reg <= (sn_reg == in_num_w) && (sd_reg == in_den_w)
                      && (op == rac_pkg::OP_CMP);
        end
        if (cmd.mul1)
        begin
            p_reg <= WORD_BITS'(sn_reg * ad_reg);
            d_reg <= WORD_BITS'(sd_reg * ad_reg);
        end
        if (cmd.mul2)
        begin
            n_reg <= p_reg + WORD_BITS'(sd_reg * an_reg);
        end
        if (cmd.gcd_init)
        begin
            x_reg <= n_reg;
            y_reg <= d_reg;
        end
        if (cmd.gcd_step)
        begin
            x_reg <= y_reg;
            y_reg <= rem;
        end
        if (cmd.save_qn)
        begin
            qn_reg <= quot;
        end
        if (cmd.store_err)
        begin
            err_reg <= 1'b1;
        end
    end

    assign status.div_done = div_done;
    assign status.y_zero   = (y_reg == '0);
    assign status.g_zero   = (x_reg == '0);
    assign status.op       = op_reg;

    assign res_num   = 32'(signed'({{32{sn_reg[WORD_BITS-1]}}, sn_reg}));
    assign res_den   = 32'(signed'({{32{sd_reg[WORD_BITS-1]}}, sd_reg}));
    assign nonzero   = (sn_reg != '0);
    assign equal     = eq_reg;
    assign div_error = err_reg;

endmodule

// ----- hdl/rac_controller.sv -----
// Controller: sequences products, the Euclid loop and the two divisions.
module rac_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  logic [2:0]       op,
    input  rac_pkg::status_t status,
    output rac_pkg::cmd_t    cmd
);

    rac_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rac_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rac_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        rac_pkg::OP_LOAD: state_next = rac_pkg::ST_GCD_START;
                        rac_pkg::OP_ADD,
                        rac_pkg::OP_DEC:  state_next = rac_pkg::ST_MUL1;
                        default:          state_next = rac_pkg::ST_OUT;
                    endcase
                end
            end
            rac_pkg::ST_MUL1:      state_next = rac_pkg::ST_MUL2;
            rac_pkg::ST_MUL2:      state_next = rac_pkg::ST_GCD_START;
            rac_pkg::ST_GCD_START:
            begin
                // hold while the pair loads
                if (gcd_first_reg)
                    state_next = rac_pkg::ST_GCD_START;
                else if (status.y_zero)
                    state_next = status.g_zero ? rac_pkg::ST_OUT : rac_pkg::ST_Q1_START;
                else
                    state_next = rac_pkg::ST_GCD_DIV;
            end
            rac_pkg::ST_GCD_DIV:
                if (status.div_done) state_next = rac_pkg::ST_GCD_START;
            rac_pkg::ST_Q1_START:  state_next = rac_pkg::ST_Q1_DIV;
            rac_pkg::ST_Q1_DIV:
                if (status.div_done) state_next = rac_pkg::ST_Q2_START;
            rac_pkg::ST_Q2_START:  state_next = rac_pkg::ST_Q2_DIV;
            rac_pkg::ST_Q2_DIV:
                if (status.div_done) state_next = rac_pkg::ST_STORE;
            rac_pkg::ST_STORE:     state_next = rac_pkg::ST_OUT;
            rac_pkg::ST_OUT:
                if (out_ready) state_next = rac_pkg::ST_IDLE;
            default:               state_next = rac_pkg::ST_IDLE;
        endcase
    end

    // outputs
    logic gcd_first_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gcd_first_reg <= 1'b0;
        else if (state_reg == rac_pkg::ST_IDLE || state_reg == rac_pkg::ST_MUL2)
            gcd_first_reg <= 1'b1;
        else if (state_reg == rac_pkg::ST_GCD_START)
            gcd_first_reg <= 1'b0;
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            rac_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                cmd.do_inc  = in_valid && (op == rac_pkg::OP_INC);
            end
            rac_pkg::ST_MUL1: cmd.mul1 = 1'b1;
            rac_pkg::ST_MUL2: cmd.mul2 = 1'b1;
            rac_pkg::ST_GCD_START:
            begin
                // the pair is loaded first, the loop tests it after
                if (gcd_first_reg)
                    cmd.gcd_init = 1'b1;
                else if (!status.y_zero)
                    cmd.div_start = 1'b1;
                else if (status.g_zero)
                    cmd.store_err = 1'b1;
            end
            rac_pkg::ST_GCD_DIV: cmd.gcd_step = status.div_done;
            rac_pkg::ST_Q1_START:
            begin
                cmd.div_num   = 1'b1;
                cmd.div_start = 1'b1;
            end
            rac_pkg::ST_Q1_DIV: cmd.save_qn = status.div_done;
            rac_pkg::ST_Q2_START:
            begin
                cmd.div_den   = 1'b1;
                cmd.div_start = 1'b1;
            end
            rac_pkg::ST_Q2_DIV: cmd.store = status.div_done;
            rac_pkg::ST_STORE:  cmd.do_none = 1'b1;
            rac_pkg::ST_OUT:    out_valid = 1'b1;
            default:            cmd = '0;
        endcase
    end

endmodule

// ----- hdl/rational_accumulator.sv -----
// Top level of the rational accumulator.
// Holds one signed fraction and applies one operation per input transaction.
// Input channel: in_valid/in_ready carry op, in_num, in_den.
// Output channel: out_valid/out_ready carry res_num, res_den, nonzero,
// equal and div_error, the state after the operation.
// One transaction is in flight at a time. Increment, compare and unused
// codes go straight to the output. Load, add and decrement run the Euclid
// loop on the shared one-bit-per-cycle divider, then two final divisions
// by the GCD; add and decrement form the products first. A zero GCD
// ends the operation with div_error set and the fraction unchanged.
// Reset sets the fraction to 0/1 and empties the output.
// When the receiver stalls, the result holds in out_valid and no new
// transaction is taken until it is delivered.
module rational_accumulator #(
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic signed [31:0] in_num,
    input  logic signed [31:0] in_den,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic               nonzero,
    output logic               equal,
    output logic               div_error
);

    rac_pkg::cmd_t    cmd;
    rac_pkg::status_t status;

    rac_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .op        (op),
        .status    (status),
        .cmd       (cmd)
    );

    rac_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (op),
        .in_num    (in_num),
        .in_den    (in_den),
        .res_num   (res_num),
        .res_den   (res_den),
        .nonzero   (nonzero),
        .equal     (equal),
        .div_error (div_error)
    );

    // never accept while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while result pending");

    // an error never comes with a state write
    a_err_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.store && cmd.store_err))
        else $error("store and error together");

    // state holds while the result waits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(res_num) && $stable(res_den))
        else $error("result changed while stalled");

endmodule
